### rtl/rmeu_pkg.sv
// rmeu_pkg: opcodes and stream field layout of the register machine execute unit
// used by the top level and by its checker; no dependencies
package rmeu_pkg;

  typedef enum logic [4:0] {
    OP_INCR  = 5'd0,
    OP_ZERO  = 5'd1,
    OP_ADD   = 5'd2,
    OP_SUB   = 5'd3,
    OP_MUL   = 5'd4,
    OP_DIV   = 5'd5,
    OP_REM   = 5'd6,
    OP_NOR   = 5'd7,
    OP_SHL   = 5'd8,
    OP_SHR   = 5'd9,
    OP_SHRS  = 5'd10,
    OP_BLT   = 5'd11,
    OP_BLTS  = 5'd12,
    OP_LD1   = 5'd13,
    OP_LD2   = 5'd14,
    OP_LD4   = 5'd15,
    OP_LD8   = 5'd16,
    OP_ST1   = 5'd17,
    OP_ST2   = 5'd18,
    OP_ST4   = 5'd19,
    OP_ST8   = 5'd20
  } op_e;

  localparam int unsigned ModeW  = 5;
  localparam int unsigned IaW    = 16;
  localparam int unsigned IdxW   = 12;
  localparam int unsigned NextW  = 17;
  localparam int unsigned WordW  = 64;
  localparam int unsigned InW    = 80;
  localparam int unsigned OutW   = 88;

  // apb byte address of the instruction count limit
  localparam logic [2:0] RegPlenAddr = 3'd0;

  // output tdata bit positions
  localparam int unsigned OutWvLsb    = 17;
  localparam int unsigned OutTakenBit = 81;
  localparam int unsigned OutHaltBit  = 82;
  localparam int unsigned OutBadBit   = 83;

endpackage

### rtl/rmeu_ram.sv
// rmeu_ram: generic single write port, single read port ram with registered read
// no dependencies
module rmeu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/register_machine_execute_unit_top.sv
// channel   | dir | handshake                    | payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | instruction, 80 bit tdata
// m_axis    | out | m_axis_tvalid/m_axis_tready  | result, 88 bit tdata
// apb       | in  | psel/penable/pwrite, pready=1| instruction count limit at address 0
//
// after reset a clearing pass zeroes the register file, during which no
// transfer is taken in. one instruction at a time: three register file reads
// over the single read port, an execute step and a write back for simple ops;
// mul sums three 32x32 partial products, div/rem produce one quotient bit a
// cycle, loads and stores move one byte at a time through the data memory.
// a held result waits in the output register while the next instruction is
// taken; the one after stalls in write back until it drains.
// depends on rmeu_pkg and rmeu_ram
module register_machine_execute_unit_top #(
  parameter int unsigned REGISTER_COUNT = 4096,
  parameter int unsigned MEMORY_BYTES   = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode[4:0], instr_address[20:5], dest_index[32:21], src_a_index[44:33],
  // src_b_index[56:45], branch_target[72:57], zeros above
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // next_address[16:0], written_value[80:17], branch_taken[81], halted[82],
  // bad_opcode[83], zeros above
  output logic [87:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned RfAw = $clog2(REGISTER_COUNT);
  localparam int unsigned MaW  = $clog2(MEMORY_BYTES);

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_RDA, ST_RDB, ST_RDD, ST_EXEC,
    ST_MUL, ST_DIV, ST_LOAD, ST_STORE, ST_WB
  } state_e;

  state_e      state_q;
  logic [16:0] plen_q;
  logic [RfAw-1:0] clr_q;
  logic [4:0]  mode_q;
  logic [15:0] ia_q, tgt_q;
  logic [RfAw-1:0] d_q, b_q;
  logic [63:0] ra_q, rb_q, rd_q, res_q, quo_q, prod_q;
  logic [63:0] rem_q;
  logic [16:0] next_q;
  logic        taken_q, bad_q, wreg_q;
  logic [6:0]  cnt_q;
  logic        out_valid_q;
  logic [87:0] out_q;

  // outcome of the execute cycle
  logic [16:0] next_d;
  logic        taken_d, bad_d, wreg_d;
  logic [63:0] res_d;
  state_e      ex_state_d;

  // register file ports
  logic            rf_we;
  logic [RfAw-1:0] rf_waddr, rf_raddr;
  logic [63:0]     rf_wdata, rf_rdata;
  // data memory ports
  logic            dm_we;
  logic [MaW-1:0]  dm_waddr, dm_raddr;
  logic [7:0]      dm_wdata, dm_rdata;

  logic        s_hs, out_free, cfg_wr;
  logic [1:0]  sz;
  logic [3:0]  nbytes;
  logic [31:0] mul_x, mul_y;
  logic [64:0] rem_sh;
  logic        div_ge;
  logic [5:0]  sh;
  logic [2:0]  byte_prev;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_hs          = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite && (paddr == rmeu_pkg::RegPlenAddr);
  assign prdata        = (paddr == rmeu_pkg::RegPlenAddr) ? {15'd0, plen_q} : 32'd0;

  assign sz     = (mode_q >= rmeu_pkg::OP_ST1) ? 2'(mode_q - rmeu_pkg::OP_ST1)
                                               : 2'(mode_q - rmeu_pkg::OP_LD1);
  assign nbytes = 4'd1 << sz;
  assign sh     = rb_q[5:0];
  assign byte_prev = 3'(cnt_q - 7'd1);

  always_comb begin
    case (state_q)
      ST_IDLE: rf_raddr = s_axis_tdata[33 +: RfAw];
      ST_RDA:  rf_raddr = b_q;
      ST_RDB:  rf_raddr = d_q;
      default: rf_raddr = d_q;
    endcase
    rf_we    = (state_q == ST_CLR) || (state_q == ST_WB && wreg_q);
    rf_waddr = (state_q == ST_CLR) ? clr_q : d_q;
    rf_wdata = (state_q == ST_CLR) ? 64'd0 : res_q;
  end

  always_comb begin
    dm_raddr = MaW'(ra_q[MaW-1:0] + MaW'(cnt_q));
    dm_we    = (state_q == ST_STORE);
    dm_waddr = MaW'(rd_q[MaW-1:0] + MaW'(cnt_q));
    dm_wdata = ra_q[8*cnt_q[2:0] +: 8];
  end

  always_comb begin
    next_d     = 17'(ia_q) + 17'd1;
    taken_d    = 1'b0;
    bad_d      = 1'b0;
    wreg_d     = 1'b1;
    res_d      = 64'd0;
    ex_state_d = ST_WB;
    case (mode_q)
      rmeu_pkg::OP_INCR: res_d = rd_q + 64'd1;
      rmeu_pkg::OP_ZERO: res_d = 64'd0;
      rmeu_pkg::OP_ADD:  res_d = ra_q + rb_q;
      rmeu_pkg::OP_SUB:  res_d = ra_q - rb_q;
      rmeu_pkg::OP_NOR:  res_d = ~(ra_q | rb_q);
      rmeu_pkg::OP_SHL:  res_d = ra_q << sh;
      rmeu_pkg::OP_SHR:  res_d = ra_q >> sh;
      rmeu_pkg::OP_SHRS: res_d = 64'($signed(ra_q) >>> sh);
      rmeu_pkg::OP_MUL:  ex_state_d = ST_MUL;
      rmeu_pkg::OP_DIV, rmeu_pkg::OP_REM: ex_state_d = ST_DIV;
      rmeu_pkg::OP_BLT, rmeu_pkg::OP_BLTS: begin
        wreg_d = 1'b0;
        if ((mode_q == rmeu_pkg::OP_BLT) ? (ra_q < rb_q)
                                         : ($signed(ra_q) < $signed(rb_q))) begin
          taken_d = 1'b1;
          next_d  = 17'(tgt_q);
        end
      end
      rmeu_pkg::OP_LD1, rmeu_pkg::OP_LD2, rmeu_pkg::OP_LD4,
      rmeu_pkg::OP_LD8: ex_state_d = ST_LOAD;
      rmeu_pkg::OP_ST1, rmeu_pkg::OP_ST2, rmeu_pkg::OP_ST4,
      rmeu_pkg::OP_ST8: begin
        wreg_d     = 1'b0;
        res_d      = (sz == 2'd3) ? ra_q
                                  : ra_q & ((64'd1 << (6'd8 << sz)) - 64'd1);
        ex_state_d = ST_STORE;
      end
      default: begin
        wreg_d = 1'b0;
        bad_d  = 1'b1;
      end
    endcase
  end

  // partial product selection
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    begin mul_x = ra_q[31:0];  mul_y = rb_q[31:0];  end
      2'd1:    begin mul_x = ra_q[31:0];  mul_y = rb_q[63:32]; end
      default: begin mul_x = ra_q[63:32]; mul_y = rb_q[31:0];  end
    endcase
  end

  // restoring division step; a zero divisor yields all ones and the dividend
  assign rem_sh = {rem_q, quo_q[63]};
  assign div_ge = rem_sh >= {1'b0, rb_q};

  rmeu_ram #(.Width(64), .Depth(REGISTER_COUNT)) u_rf (
    .clk_i, .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .raddr_i(rf_raddr), .rdata_o(rf_rdata)
  );

  rmeu_ram #(.Width(8), .Depth(MEMORY_BYTES)) u_dm (
    .clk_i, .we_i(dm_we), .waddr_i(dm_waddr), .wdata_i(dm_wdata),
    .raddr_i(dm_raddr), .rdata_o(dm_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      plen_q      <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      wreg_q      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        plen_q <= pwdata[16:0];
      end
      if (state_q == ST_WB && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLR: begin
          clr_q <= RfAw'(clr_q + 1'b1);
          if (clr_q == {RfAw{1'b1}}) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_hs) begin
            mode_q  <= s_axis_tdata[4:0];
            ia_q    <= s_axis_tdata[20:5];
            d_q     <= s_axis_tdata[21 +: RfAw];
            b_q     <= s_axis_tdata[45 +: RfAw];
            tgt_q   <= s_axis_tdata[72:57];
            state_q <= ST_RDA;
          end
        end
        ST_RDA: begin
          ra_q    <= rf_rdata;
          state_q <= ST_RDB;
        end
        ST_RDB: begin
          rb_q    <= rf_rdata;
          state_q <= ST_RDD;
        end
        ST_RDD: begin
          rd_q    <= rf_rdata;
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          next_q  <= next_d;
          taken_q <= taken_d;
          bad_q   <= bad_d;
          wreg_q  <= wreg_d;
          res_q   <= res_d;
          rem_q   <= '0;
          quo_q   <= ra_q;
          cnt_q   <= '0;
          state_q <= ex_state_d;
        end
        ST_MUL: begin
          prod_q <= mul_x * mul_y;
          cnt_q  <= cnt_q + 7'd1;
          case (cnt_q[1:0])
            2'd0:    ;
            2'd1:    res_q <= prod_q;
            default: res_q <= res_q + {prod_q[31:0], 32'd0};
          endcase
          if (cnt_q[1:0] == 2'd3) begin
            state_q <= ST_WB;
          end
        end
        ST_DIV: begin
          rem_q <= div_ge ? 64'(rem_sh - {1'b0, rb_q}) : rem_sh[63:0];
          quo_q <= {quo_q[62:0], div_ge};
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd63) begin
            res_q   <= (mode_q == rmeu_pkg::OP_DIV) ? {quo_q[62:0], div_ge}
                       : (div_ge ? 64'(rem_sh - {1'b0, rb_q}) : rem_sh[63:0]);
            state_q <= ST_WB;
          end
        end
        ST_LOAD: begin
          // address of byte cnt issued, byte cnt-1 returns
          if (cnt_q != 7'd0) begin
            res_q[8*byte_prev +: 8] <= dm_rdata;
          end
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'(nbytes)) begin
            state_q <= ST_WB;
          end
        end
        ST_STORE: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'(nbytes - 4'd1)) begin
            state_q <= ST_WB;
          end
        end
        ST_WB: begin
          if (out_free) begin
            out_q   <= {4'd0, bad_q, (next_q >= plen_q), taken_q, res_q, next_q};
            wreg_q  <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/rmeu_checker.sv
// rmeu_checker: port level assertions for the execute unit, bound to the top level
// depends on rmeu_pkg
module rmeu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // one instruction at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("transfer taken while busy");

  // no transfer during the clearing pass right after reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !s_axis_tready)
    else $error("ready during register file clear");

  // bad opcodes change nothing and take no branch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[rmeu_pkg::OutBadBit] |->
      !m_axis_tdata[rmeu_pkg::OutTakenBit] &&
      m_axis_tdata[rmeu_pkg::OutWvLsb +: rmeu_pkg::WordW] == 64'd0)
    else $error("bad opcode with side effects");

endmodule

bind register_machine_execute_unit_top rmeu_checker u_rmeu_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
